@@ rtl/assert_macros.svh @@
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

@@ rtl/qdt_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package qdt_pkg;

    localparam int DATA_W = 32;
    localparam int ADDR_W = 10;
    localparam int REQ_W  = 2;
    localparam int IRQ_W  = 4;
    localparam int REG_W  = 6;
    localparam int PRE_W  = 8;

    // request codes
    localparam logic [REQ_W-1:0] REQ_READ  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_WRITE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_TICK  = 2'd2;

    // register word offsets
    localparam logic [REG_W-1:0] REG_LOAD    = 6'd0;
    localparam logic [REG_W-1:0] REG_VALUE   = 6'd1;
    localparam logic [REG_W-1:0] REG_CONTROL = 6'd2;
    localparam logic [REG_W-1:0] REG_INTCLR  = 6'd3;
    localparam logic [REG_W-1:0] REG_RIS     = 6'd4;
    localparam logic [REG_W-1:0] REG_MIS     = 6'd5;
    localparam logic [REG_W-1:0] REG_BGLOAD  = 6'd6;

    // control word bits
    localparam int CT_ONESHOT  = 0;
    localparam int CT_WIDE     = 1;
    localparam int CT_PRE_LO   = 2;
    localparam int CT_PRE_HI   = 3;
    localparam int CT_IRQ_EN   = 5;
    localparam int CT_PERIODIC = 6;
    localparam int CT_ENABLE   = 7;

    // prescaler select codes
    localparam logic [1:0] PRE_DIV16  = 2'd1;
    localparam logic [1:0] PRE_DIV256 = 2'd2;

    localparam logic [DATA_W-1:0] CTRL_RESET   = 32'h0000_0020;
    localparam logic [DATA_W-1:0] LIMIT_WIDE   = 32'hffff_ffff;
    localparam logic [DATA_W-1:0] LIMIT_NARROW = 32'h0000_ffff;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic execute;
    } t_dp_cmd;

    // datapath to one timer
    typedef struct packed {
        logic              tick;
        logic              wr_load;
        logic              wr_ctrl;
        logic              wr_intclr;
        logic              wr_bgload;
        logic [DATA_W-1:0] data;
    } t_tmr_cmd;

    // one timer to datapath
    typedef struct packed {
        logic [DATA_W-1:0] reload;
        logic [DATA_W-1:0] count;
        logic [DATA_W-1:0] ctrl;
        logic              latch;
        logic              irq_next;
    } t_tmr_stat;

endpackage

`default_nettype wire

@@ rtl/qdt_timer.sv @@
`timescale 1ns / 1ps
`default_nettype none

module qdt_timer (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire qdt_pkg::t_tmr_cmd  i_cmd,
    output qdt_pkg::t_tmr_stat      o_stat
);
    import qdt_pkg::*;

    logic [DATA_W-1:0] r_ctrl, n_ctrl;
    logic [DATA_W-1:0] r_reload, n_reload;
    logic [DATA_W-1:0] r_count, n_count;
    logic              r_latch, n_latch;
    logic [PRE_W-1:0]  r_pre, n_pre;
    logic              r_running, n_running;
    logic [PRE_W:0]    pre_inc;
    logic [PRE_W:0]    divisor;

    // free-running when neither oneshot nor periodic
    function automatic logic [DATA_W-1:0] eff_limit(input logic [DATA_W-1:0] ctrl,
                                                    input logic [DATA_W-1:0] reload);
        logic [DATA_W-1:0] lim;
        if (!ctrl[CT_PERIODIC] && !ctrl[CT_ONESHOT]) begin
            lim = ctrl[CT_WIDE] ? LIMIT_WIDE : LIMIT_NARROW;
        end else begin
            lim = reload;
        end
        return lim;
    endfunction

    assign pre_inc = {1'b0, r_pre} + 9'd1;

    always_comb begin
        unique case (r_ctrl[CT_PRE_HI:CT_PRE_LO])
            PRE_DIV16:  divisor = 9'd16;
            PRE_DIV256: divisor = 9'd256;
            default:    divisor = 9'd1;
        endcase
    end

    always_comb begin
        n_ctrl    = r_ctrl;
        n_reload  = r_reload;
        n_count   = r_count;
        n_latch   = r_latch;
        n_pre     = r_pre;
        n_running = r_running;
        if (i_cmd.tick && r_running) begin
            if (pre_inc >= divisor) begin
                n_pre = '0;
                if (r_count <= 32'd1) begin
                    n_latch = 1'b1;
                    if (r_ctrl[CT_ONESHOT]) begin
                        n_count   = '0;
                        n_running = 1'b0;
                    end else begin
                        n_count = eff_limit(r_ctrl, r_reload);
                    end
                end else begin
                    n_count = r_count - 32'd1;
                end
            end else begin
                n_pre = pre_inc[PRE_W-1:0];
            end
        end
        if (i_cmd.wr_load) begin
            n_reload = i_cmd.data;
            n_count  = eff_limit(r_ctrl, i_cmd.data);
        end
        if (i_cmd.wr_ctrl) begin
            n_ctrl    = i_cmd.data;
            n_running = i_cmd.data[CT_ENABLE];
            n_pre     = '0;
            if (i_cmd.data[CT_ENABLE]) begin
                n_count = eff_limit(i_cmd.data, r_reload);
            end
        end
        if (i_cmd.wr_intclr) begin
            n_latch = 1'b0;
        end
        if (i_cmd.wr_bgload) begin
            n_reload = i_cmd.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl    <= CTRL_RESET;
            r_reload  <= '0;
            r_count   <= '0;
            r_latch   <= 1'b0;
            r_pre     <= '0;
            r_running <= 1'b0;
        end else begin
            r_ctrl    <= n_ctrl;
            r_reload  <= n_reload;
            r_count   <= n_count;
            r_latch   <= n_latch;
            r_pre     <= n_pre;
            r_running <= n_running;
        end
    end

    assign o_stat.reload   = r_reload;
    assign o_stat.count    = r_count;
    assign o_stat.ctrl     = r_ctrl;
    assign o_stat.latch    = r_latch;
    assign o_stat.irq_next = n_latch & n_ctrl[CT_IRQ_EN];

endmodule

`default_nettype wire

@@ rtl/qdt_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none

module qdt_datapath #(
    parameter int NUM_TIMERS = 4
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire qdt_pkg::t_dp_cmd              i_cmd,
    input  wire logic [qdt_pkg::REQ_W-1:0]     i_req_type,
    input  wire logic [qdt_pkg::ADDR_W-1:0]    i_address,
    input  wire logic [qdt_pkg::DATA_W-1:0]    i_write_data,
    output logic      [qdt_pkg::DATA_W-1:0]    o_read_data,
    output logic      [qdt_pkg::IRQ_W-1:0]     o_irq_lines,
    output logic                               o_bad_access
);
    import qdt_pkg::*;

    logic [REQ_W-1:0]  r_req;
    logic [ADDR_W-1:0] r_addr;
    logic [DATA_W-1:0] r_wdata;
    logic [DATA_W-1:0] r_read_data;
    logic [IRQ_W-1:0]  r_irq_lines;
    logic              r_bad_access;

    logic [1:0]        timer_idx;
    logic [REG_W-1:0]  reg_off;
    logic              idx_ok;
    logic              is_wr;
    t_tmr_stat         sel_stat;
    t_tmr_stat         tmr_stat [NUM_TIMERS];
    t_tmr_cmd          tmr_cmd  [NUM_TIMERS];
    logic [IRQ_W-1:0]  irq_vec;
    logic [DATA_W-1:0] rd;
    logic              bad;

    assign timer_idx = r_addr[ADDR_W-1:ADDR_W-2];
    assign reg_off   = r_addr[ADDR_W-3:2];
    assign idx_ok    = {1'b0, timer_idx} < 3'(NUM_TIMERS);
    assign is_wr     = (r_req == REQ_WRITE);

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req   <= i_req_type;
            r_addr  <= i_address;
            r_wdata <= i_write_data;
        end
    end

    for (genvar g = 0; g < NUM_TIMERS; g++) begin : g_tmr
        logic wsel;
        assign wsel = i_cmd.execute && is_wr && idx_ok && (timer_idx == 2'(g));
        assign tmr_cmd[g].tick      = i_cmd.execute && (r_req == REQ_TICK);
        assign tmr_cmd[g].wr_load   = wsel && (reg_off == REG_LOAD);
        assign tmr_cmd[g].wr_ctrl   = wsel && (reg_off == REG_CONTROL);
        assign tmr_cmd[g].wr_intclr = wsel && (reg_off == REG_INTCLR);
        assign tmr_cmd[g].wr_bgload = wsel && (reg_off == REG_BGLOAD);
        assign tmr_cmd[g].data      = r_wdata;

        qdt_timer u_timer (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (tmr_cmd[g]),
            .o_stat  (tmr_stat[g])
        );
    end

    always_comb begin
        sel_stat = '0;
        irq_vec  = '0;
        for (int i = 0; i < NUM_TIMERS; i++) begin
            if (timer_idx == 2'(i)) begin
                sel_stat = tmr_stat[i];
            end
            irq_vec[i] = tmr_stat[i].irq_next;
        end
    end

    // read mux and offset decode
    always_comb begin
        rd  = '0;
        bad = 1'b0;
        if (r_req == REQ_READ || r_req == REQ_WRITE) begin
            if (!idx_ok) begin
                bad = 1'b1;
            end else if (!is_wr) begin
                unique case (reg_off)
                    REG_LOAD, REG_BGLOAD: rd = sel_stat.reload;
                    REG_VALUE:            rd = sel_stat.count;
                    REG_CONTROL:          rd = sel_stat.ctrl;
                    REG_RIS:              rd = {31'b0, sel_stat.latch};
                    REG_MIS:              rd = {31'b0, sel_stat.latch & sel_stat.ctrl[CT_IRQ_EN]};
                    default:              bad = 1'b1;
                endcase
            end else begin
                unique case (reg_off)
                    REG_LOAD, REG_VALUE, REG_CONTROL, REG_INTCLR, REG_BGLOAD: bad = 1'b0;
                    default: bad = 1'b1;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.execute) begin
            r_read_data  <= rd;
            r_irq_lines  <= irq_vec;
            r_bad_access <= bad;
        end
    end

    assign o_read_data  = r_read_data;
    assign o_irq_lines  = r_irq_lines;
    assign o_bad_access = r_bad_access;

endmodule

`default_nettype wire

@@ rtl/qdt_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module qdt_ctrl (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_start,
    output logic              o_busy,
    output logic              o_done,
    output qdt_pkg::t_dp_cmd  o_cmd
);
    import qdt_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   r_done;

    always_comb begin
        unique case (r_state)
            ST_IDLE: n_state = i_start ? ST_EXEC : ST_IDLE;
            ST_EXEC: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == ST_EXEC);
        end
    end

    assign o_busy        = (r_state != ST_IDLE);
    assign o_done        = r_done;
    assign o_cmd.capture = i_start && (r_state == ST_IDLE);
    assign o_cmd.execute = (r_state == ST_EXEC);

endmodule

`default_nettype wire

@@ rtl/quad_down_timer_regs.sv @@
`timescale 1ns / 1ps
`default_nettype none
// quad down-counting timer register block
// - one transaction per start pulse: a register read, a register write or one
//   base clock tick that all timers see; i_req_type, i_address, i_write_data
//   are sampled at the edge where start is high and busy is low
// - address bits 9:8 pick the timer, bits 7:2 the register (load, value,
//   control, intclr, ris, mis, bgload); other offsets read 0 and flag o_bad_access
// - every transaction gives one result: o_done is high for exactly one cycle
//   with o_read_data, o_irq_lines and o_bad_access; the receiver cannot stall
//   it, so the result must be taken in that cycle
// - the accepting edge moves the controller into its execute state; at the end of
//   that state the result registers and o_done are loaded together
// - a new start is not taken during the single execute state of the controller,
//   in which all timer registers update
// - busy is high only in the execute cycle; a new start may be taken while
//   the previous result is still on the outputs
// - synchronous active-low reset: controls 0x20, counts, limits, latches and
//   prescalers zero, all timers stopped, no result pending
module quad_down_timer_regs #(
    parameter int NUM_TIMERS = 4
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [qdt_pkg::REQ_W-1:0]     i_req_type,
    input  wire logic [qdt_pkg::ADDR_W-1:0]    i_address,
    input  wire logic [qdt_pkg::DATA_W-1:0]    i_write_data,
    output logic                               o_done,
    output logic      [qdt_pkg::DATA_W-1:0]    o_read_data,
    output logic      [qdt_pkg::IRQ_W-1:0]     o_irq_lines,
    output logic                               o_bad_access
);
    import qdt_pkg::*;

    // command from the sequencer to the register datapath
    t_dp_cmd dp_cmd;

    qdt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_done  (o_done),
        .o_cmd   (dp_cmd)
    );

    // timers, decode, read mux and result registers
    qdt_datapath #(
        .NUM_TIMERS (NUM_TIMERS)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (dp_cmd),
        .i_req_type   (i_req_type),
        .i_address    (i_address),
        .i_write_data (i_write_data),
        .o_read_data  (o_read_data),
        .o_irq_lines  (o_irq_lines),
        .o_bad_access (o_bad_access)
    );

endmodule

`default_nettype wire

@@ rtl/qdt_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module qdt_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        o_done,
    input wire logic [31:0] o_read_data,
    input wire logic        o_bad_access
);

    // an accepted transaction enters the execute cycle
    `ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy)

    // execute cycle is followed by the result strobe
    `ASSERT_NEXT(a_busy_done, i_clk, i_rst_n, busy, o_done)

    // a result strobe is never followed directly by a second one
    `ASSERT_NEXT(a_done_single, i_clk, i_rst_n, o_done, !o_done)

    // a bad offset never returns data
    `ASSERT_IMPL(a_bad_zero, i_clk, i_rst_n, o_done && o_bad_access, o_read_data == 32'd0)

endmodule

bind quad_down_timer_regs qdt_checker u_qdt_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .o_done       (o_done),
    .o_read_data  (o_read_data),
    .o_bad_access (o_bad_access)
);

`default_nettype wire
